// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL module of the selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== rtl/wlls_pkg.sv =====
// Types and constants of the weighted least loaded selector.
package wlls_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int POS_W      = $clog2(POOL_DEPTH);
  localparam int LEN_W      = POS_W + 1;
  localparam int ID_W       = POS_W + 1;
  localparam int NUM_IDS    = 2 * POOL_DEPTH;
  localparam int COUNT_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = COUNT_W + WEIGHT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NONE   = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BAD_ID = 2'd3
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic                family;
    logic [WEIGHT_W-1:0] weight;
    logic [1:0]          type_mask;
    logic [ID_W-1:0]     target_id;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    chosen_id;
    logic [COUNT_W-1:0] chosen_count;
    logic [1:0]         families_seen;
  } res_t;

endpackage

// ===== rtl/weighted_least_loaded_selector.sv =====
// Weighted least loaded selector: two id heaps kept in synchronous memories.
//
//   channel   direction  handshake            word
//   command   in         start, busy          cmd_i
//   result    out        done_o strobe        res_o
//
// Each word is worked by a sequencer that reads, compares and writes back the
// heap and entry memories; every read is registered. The run of a word is set by
// its heap walk: an add sifts the new id up, an open bumps the chosen count and
// sifts it down from the root, a close lowers the count and sifts it up, and a
// remove moves the last id into the hole and sifts it up and then down.
// Reset clears the valid bits, heap lengths and seen mask at once, with no sweep.
// busy is high after the accept until the result cycle, in which a new word may be accepted.
`include "assert_macros.svh"

module weighted_least_loaded_selector (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wlls_pkg::cmd_t cmd_i,
  output logic           done_o,
  output wlls_pkg::res_t res_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_OP_R6, ST_OP_C4, ST_OP_C6, ST_OP_SEL, ST_TG_LD,
    ST_LD_H, ST_LD_E, ST_LD_W, ST_SU_RDH, ST_SU_RDE, ST_SU_MUL, ST_SU_CMP,
    ST_SU_DONE, ST_SD_CHK, ST_SD_RL, ST_SD_RR, ST_SD_RRD, ST_SD_CMP1,
    ST_SD_MUL2, ST_SD_CMP2, ST_SD_DONE, ST_FIN
  } state_e;

  state_e state_q;
  wlls_pkg::cmd_t cmd_q;

  logic [wlls_pkg::NUM_IDS-1:0] valid_q;
  logic [1:0][wlls_pkg::LEN_W-1:0] len_q;
  logic [1:0] seen_q;
  logic phase_q;

  logic fam_q;
  logic [wlls_pkg::POS_W-1:0] pos_q, hole_q, ld_pos_q, pick_pos_q;
  logic [wlls_pkg::ID_W-1:0] item_id_q, a_id_q, b_id_q;
  logic [wlls_pkg::COUNT_W-1:0] item_cnt_q, a_cnt_q, b_cnt_q;
  logic [wlls_pkg::WEIGHT_W-1:0] item_wt_q, a_wt_q, b_wt_q;
  logic [wlls_pkg::PROD_W-1:0] prod1_q, prod2_q;
  wlls_pkg::status_e res_status_q;
  logic [wlls_pkg::ID_W-1:0] res_id_q;
  logic [wlls_pkg::COUNT_W-1:0] res_cnt_q;

  logic [wlls_pkg::ID_W-1:0] hmem [wlls_pkg::NUM_IDS];
  logic [wlls_pkg::COUNT_W-1:0] cmem [wlls_pkg::NUM_IDS];
  logic [wlls_pkg::WEIGHT_W-1:0] wmem [wlls_pkg::NUM_IDS];
  logic [wlls_pkg::POS_W-1:0] pmem [wlls_pkg::NUM_IDS];

  logic [wlls_pkg::ID_W-1:0] h_rd, h_ra, h_wa, h_wd, e_ra, c_wa, w_wa, p_wa, p_ra;
  logic [wlls_pkg::COUNT_W-1:0] c_rd, c_wd;
  logic [wlls_pkg::WEIGHT_W-1:0] w_rd, w_wd;
  logic [wlls_pkg::POS_W-1:0] p_rd, p_wd;
  logic h_we, c_we, w_we, p_we;

  logic [wlls_pkg::COUNT_W-1:0] m1a, m2a;
  logic [wlls_pkg::WEIGHT_W-1:0] m1b, m2b;
  logic lt;

  logic free_found;
  logic [wlls_pkg::POS_W-1:0] free_slot;
  logic [wlls_pkg::ID_W-1:0] new_id;
  logic [wlls_pkg::WEIGHT_W-1:0] new_wt;
  logic [wlls_pkg::LEN_W-1:0] cur_len, new_len;
  logic [wlls_pkg::LEN_W:0] child_l, child_r;
  logic [wlls_pkg::POS_W-1:0] up_pos;
  logic have4, have6, sel6;
  logic [wlls_pkg::ID_W-1:0] sel_id;
  logic [wlls_pkg::COUNT_W-1:0] sel_cnt, open_cnt, dec_cnt;
  logic [wlls_pkg::WEIGHT_W-1:0] sel_wt;
  logic tg_valid;

  assign busy     = (state_q != ST_IDLE);
  assign lt       = (prod1_q < prod2_q);
  assign cur_len  = len_q[fam_q];
  assign child_l  = {1'b0, pos_q, 1'b1};
  assign child_r  = child_l + 1'b1;
  assign up_pos   = (pos_q - 1'b1) >> 1;
  assign new_id   = {cmd_q.family, free_slot};
  assign new_wt   = (cmd_q.weight == '0) ? wlls_pkg::WEIGHT_W'(1) : cmd_q.weight;
  assign new_len  = len_q[cmd_q.target_id[wlls_pkg::ID_W-1]] - 1'b1;
  assign tg_valid = valid_q[cmd_q.target_id];
  assign have4    = cmd_q.type_mask[0] && (len_q[0] != '0);
  assign have6    = cmd_q.type_mask[1] && (len_q[1] != '0);
  assign sel6     = have6 && (!have4 || lt);
  assign sel_id   = sel6 ? b_id_q : a_id_q;
  assign sel_cnt  = sel6 ? b_cnt_q : a_cnt_q;
  assign sel_wt   = sel6 ? b_wt_q : a_wt_q;
  assign open_cnt = (sel_cnt == wlls_pkg::COUNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
  assign dec_cnt  = (c_rd == '0) ? c_rd : c_rd - 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = wlls_pkg::POOL_DEPTH - 1; s >= 0; s--) begin
      if (!valid_q[{cmd_q.family, wlls_pkg::POS_W'(s)}]) begin
        free_found = 1'b1;
        free_slot  = wlls_pkg::POS_W'(s);
      end
    end
  end

  always_comb begin
    h_ra = '0;
    e_ra = '0;
    p_ra = cmd_q.target_id;
    h_we = 1'b0;
    h_wa = {fam_q, pos_q};
    h_wd = item_id_q;
    p_we = 1'b0;
    p_wa = item_id_q;
    p_wd = pos_q;
    c_we = 1'b0;
    c_wa = item_id_q;
    c_wd = '0;
    w_we = 1'b0;
    w_wa = new_id;
    w_wd = new_wt;
    m1a  = c_rd;
    m1b  = a_wt_q;
    m2a  = a_cnt_q;
    m2b  = w_rd;
    case (state_q)
      ST_DISP: begin
        e_ra = cmd_q.target_id;
        if (cmd_q.mode == wlls_pkg::MODE_ADD && free_found) begin
          w_we = 1'b1;
          c_we = 1'b1;
          c_wa = new_id;
        end
      end
      ST_OP_R6: begin
        h_ra = {1'b1, wlls_pkg::POS_W'(0)};
        e_ra = h_rd;
      end
      ST_OP_C4: e_ra = h_rd;
      ST_OP_SEL: begin
        c_we = have4 || have6;
        c_wa = sel_id;
        c_wd = open_cnt;
      end
      ST_TG_LD: begin
        if (cmd_q.mode == wlls_pkg::MODE_CLOSE) begin
          c_we = 1'b1;
          c_wa = cmd_q.target_id;
          c_wd = dec_cnt;
        end
      end
      ST_LD_H: h_ra = {fam_q, ld_pos_q};
      ST_LD_E: e_ra = h_rd;
      ST_SU_RDH: h_ra = {fam_q, up_pos};
      ST_SU_RDE: e_ra = h_rd;
      ST_SU_MUL: begin
        m1a = item_cnt_q;
        m1b = w_rd;
        m2a = c_rd;
        m2b = item_wt_q;
      end
      ST_SU_CMP: begin
        if (lt) begin
          h_we = 1'b1;
          h_wd = a_id_q;
          p_we = 1'b1;
          p_wa = a_id_q;
        end
      end
      ST_SU_DONE, ST_SD_DONE: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      ST_SD_CHK: h_ra = {fam_q, child_l[wlls_pkg::POS_W-1:0]};
      ST_SD_RL: begin
        e_ra = h_rd;
        h_ra = {fam_q, child_r[wlls_pkg::POS_W-1:0]};
      end
      ST_SD_RR: e_ra = h_rd;
      ST_SD_MUL2: begin
        m1a = a_cnt_q;
        m1b = item_wt_q;
        m2a = item_cnt_q;
        m2b = a_wt_q;
      end
      ST_SD_CMP2: begin
        if (lt) begin
          h_we = 1'b1;
          h_wd = a_id_q;
          p_we = 1'b1;
          p_wa = a_id_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[h_wa] <= h_wd;
    h_rd <= hmem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_wa] <= c_wd;
    c_rd <= cmem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_wa] <= w_wd;
    w_rd <= wmem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem[p_wa] <= p_wd;
    p_rd <= pmem[p_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      phase_q <= 1'b0;
      done_o  <= 1'b0;
      res_o   <= '0;
    end else begin
      done_o  <= 1'b0;
      prod1_q <= m1a * m1b;
      prod2_q <= m2a * m2b;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= ST_DISP;
          end
        end
        ST_DISP: begin
          res_status_q <= wlls_pkg::STAT_OK;
          res_id_q     <= '0;
          res_cnt_q    <= '0;
          case (cmd_q.mode)
            wlls_pkg::MODE_ADD: begin
              if (!free_found) begin
                res_status_q <= wlls_pkg::STAT_FULL;
                state_q      <= ST_FIN;
              end else begin
                res_id_q                <= new_id;
                valid_q[new_id]         <= 1'b1;
                len_q[cmd_q.family]     <= len_q[cmd_q.family] + 1'b1;
                seen_q[cmd_q.family]    <= 1'b1;
                fam_q                   <= cmd_q.family;
                pos_q     <= len_q[cmd_q.family][wlls_pkg::POS_W-1:0];
                item_id_q               <= new_id;
                item_cnt_q              <= '0;
                item_wt_q               <= new_wt;
                state_q                 <= ST_SU_RDH;
              end
            end
            wlls_pkg::MODE_OPEN: state_q <= ST_OP_R6;
            default: begin
              res_id_q <= cmd_q.target_id;
              if (!tg_valid) begin
                res_status_q <= wlls_pkg::STAT_BAD_ID;
                state_q      <= ST_FIN;
              end else begin
                state_q <= ST_TG_LD;
              end
            end
          endcase
        end
        ST_OP_R6: begin
          a_id_q  <= h_rd;
          state_q <= ST_OP_C4;
        end
        ST_OP_C4: begin
          a_cnt_q <= c_rd;
          a_wt_q  <= w_rd;
          b_id_q  <= h_rd;
          state_q <= ST_OP_C6;
        end
        ST_OP_C6: begin
          b_cnt_q <= c_rd;
          b_wt_q  <= w_rd;
          state_q <= ST_OP_SEL;
        end
        ST_OP_SEL: begin
          if (!(have4 || have6)) begin
            res_status_q <= wlls_pkg::STAT_NONE;
            state_q      <= ST_FIN;
          end else begin
            res_id_q   <= sel_id;
            res_cnt_q  <= open_cnt;
            item_id_q  <= sel_id;
            item_cnt_q <= open_cnt;
            item_wt_q  <= sel_wt;
            fam_q      <= sel6;
            pos_q      <= '0;
            state_q    <= ST_SD_CHK;
          end
        end
        ST_TG_LD: begin
          fam_q     <= cmd_q.target_id[wlls_pkg::ID_W-1];
          pos_q     <= p_rd;
          hole_q    <= p_rd;
          item_id_q <= cmd_q.target_id;
          item_wt_q <= w_rd;
          if (cmd_q.mode == wlls_pkg::MODE_CLOSE) begin
            item_cnt_q <= dec_cnt;
            res_cnt_q  <= dec_cnt;
            state_q    <= ST_SU_RDH;
          end else begin
            res_cnt_q                   <= c_rd;
            valid_q[cmd_q.target_id]    <= 1'b0;
            len_q[cmd_q.target_id[wlls_pkg::ID_W-1]] <= new_len;
            ld_pos_q  <= new_len[wlls_pkg::POS_W-1:0];
            phase_q   <= 1'b0;
            if ({1'b0, p_rd} < new_len) begin
              state_q <= ST_LD_H;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_LD_H: state_q <= ST_LD_E;
        ST_LD_E: begin
          item_id_q <= h_rd;
          state_q   <= ST_LD_W;
        end
        ST_LD_W: begin
          item_cnt_q <= c_rd;
          item_wt_q  <= w_rd;
          pos_q      <= hole_q;
          if (!phase_q) begin
            phase_q <= 1'b1;
            state_q <= ST_SU_RDH;
          end else begin
            state_q <= ST_SD_CHK;
          end
        end
        ST_SU_RDH: begin
          if (pos_q == '0) begin
            state_q <= ST_SU_DONE;
          end else begin
            state_q <= ST_SU_RDE;
          end
        end
        ST_SU_RDE: begin
          a_id_q  <= h_rd;
          state_q <= ST_SU_MUL;
        end
        ST_SU_MUL: state_q <= ST_SU_CMP;
        ST_SU_CMP: begin
          if (lt) begin
            pos_q   <= up_pos;
            state_q <= ST_SU_RDH;
          end else begin
            state_q <= ST_SU_DONE;
          end
        end
        ST_SU_DONE: begin
          if (cmd_q.mode == wlls_pkg::MODE_REMOVE) begin
            ld_pos_q <= hole_q;
            state_q  <= ST_LD_H;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_SD_CHK: begin
          if (child_l >= {1'b0, cur_len}) begin
            state_q <= ST_SD_DONE;
          end else begin
            state_q <= ST_SD_RL;
          end
        end
        ST_SD_RL: begin
          a_id_q  <= h_rd;
          state_q <= ST_SD_RR;
        end
        ST_SD_RR: begin
          a_cnt_q <= c_rd;
          a_wt_q  <= w_rd;
          b_id_q  <= h_rd;
          state_q <= ST_SD_RRD;
        end
        ST_SD_RRD: begin
          b_cnt_q <= c_rd;
          b_wt_q  <= w_rd;
          state_q <= ST_SD_CMP1;
        end
        ST_SD_CMP1: begin
          if ((child_r < {1'b0, cur_len}) && lt) begin
            a_id_q     <= b_id_q;
            a_cnt_q    <= b_cnt_q;
            a_wt_q     <= b_wt_q;
            pick_pos_q <= child_r[wlls_pkg::POS_W-1:0];
          end else begin
            pick_pos_q <= child_l[wlls_pkg::POS_W-1:0];
          end
          state_q <= ST_SD_MUL2;
        end
        ST_SD_MUL2: state_q <= ST_SD_CMP2;
        ST_SD_CMP2: begin
          if (lt) begin
            pos_q   <= pick_pos_q;
            state_q <= ST_SD_CHK;
          end else begin
            state_q <= ST_SD_DONE;
          end
        end
        ST_SD_DONE: state_q <= ST_FIN;
        ST_FIN: begin
          done_o              <= 1'b1;
          res_o.status        <= res_status_q;
          res_o.chosen_id     <= res_id_q;
          res_o.chosen_count  <= res_cnt_q;
          res_o.families_seen <= seen_q;
          state_q             <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_len_bound, (len_q[0] <= wlls_pkg::LEN_W'(wlls_pkg::POOL_DEPTH)) && (len_q[1] <= wlls_pkg::LEN_W'(wlls_pkg::POOL_DEPTH)), "heap length above pool depth")
  `ASSERT_CLK(a_v4_count, $countones(valid_q[wlls_pkg::POOL_DEPTH-1:0]) == int'(len_q[0]), "v4 valid bits disagree with heap length")
  `ASSERT_CLK(a_v6_count, $countones(valid_q[wlls_pkg::NUM_IDS-1:wlls_pkg::POOL_DEPTH]) == int'(len_q[1]), "v6 valid bits disagree with heap length")
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `ASSERT_CLK(a_done_idle, !done_o || !busy, "result shown while a word is still in work")

endmodule

// ===== dv/testbench.sv =====
// Testbench of the weighted least loaded selector with a heap predictor and scoreboard.
`timescale 1ns / 100ps

module testbench;

  class load_scoreboard;
    logic [wlls_pkg::WEIGHT_W-1:0] wgt [wlls_pkg::NUM_IDS];
    logic [wlls_pkg::COUNT_W-1:0]  cnt [wlls_pkg::NUM_IDS];
    bit                            live [wlls_pkg::NUM_IDS];
    int unsigned                   slot_of [wlls_pkg::NUM_IDS];
    int unsigned                   heap [2][wlls_pkg::POOL_DEPTH];
    int unsigned                   hlen [2];
    logic [1:0]                    seen;
    wlls_pkg::res_t                pending [$];
    int                            errors;

    function new();
      for (int i = 0; i < wlls_pkg::NUM_IDS; i++) begin
        live[i] = 0;
      end
      hlen[0] = 0;
      hlen[1] = 0;
      seen = '0;
      errors = 0;
    endfunction

    function bit lighter(int unsigned a, int unsigned b);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = 64'(cnt[a]) * 64'(wgt[b]);
      rhs = 64'(cnt[b]) * 64'(wgt[a]);
      return lhs < rhs;
    endfunction

    function void place(int unsigned f, int unsigned pos, int unsigned id);
      heap[f][pos] = id;
      slot_of[id] = pos;
    endfunction

    function void sift_up(int unsigned f, int unsigned pos);
      int unsigned item;
      int unsigned up;
      item = heap[f][pos];
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!lighter(item, heap[f][up])) break;
        place(f, pos, heap[f][up]);
        pos = up;
      end
      place(f, pos, item);
    endfunction

    function void sift_down(int unsigned f, int unsigned pos);
      int unsigned item;
      int unsigned l;
      int unsigned pick;
      item = heap[f][pos];
      forever begin
        l = 2 * pos + 1;
        if (l >= hlen[f]) break;
        pick = l;
        if (l + 1 < hlen[f] && lighter(heap[f][l + 1], heap[f][l])) pick = l + 1;
        if (!lighter(heap[f][pick], item)) break;
        place(f, pos, heap[f][pick]);
        pos = pick;
      end
      place(f, pos, item);
    endfunction

    function void note_cmd(wlls_pkg::cmd_t c);
      wlls_pkg::res_t r;
      int unsigned f;
      int unsigned s;
      int unsigned id;
      int unsigned pos;
      bit have;
      int unsigned sel;
      r = '0;
      r.status = wlls_pkg::STAT_OK;
      case (c.mode)
        wlls_pkg::MODE_ADD: begin
          f = c.family;
          s = 0;
          while (s < wlls_pkg::POOL_DEPTH && live[f * wlls_pkg::POOL_DEPTH + s]) s++;
          if (s >= wlls_pkg::POOL_DEPTH || hlen[f] >= wlls_pkg::POOL_DEPTH) begin
            r.status = wlls_pkg::STAT_FULL;
          end else begin
            id = f * wlls_pkg::POOL_DEPTH + s;
            live[id] = 1;
            wgt[id] = (c.weight == '0) ? wlls_pkg::WEIGHT_W'(1) : c.weight;
            cnt[id] = '0;
            pos = hlen[f];
            hlen[f] = pos + 1;
            place(f, pos, id);
            sift_up(f, pos);
            seen[f] = 1'b1;
            r.chosen_id = wlls_pkg::ID_W'(id);
          end
        end
        wlls_pkg::MODE_OPEN: begin
          have = 0;
          sel = 0;
          for (int unsigned g = 0; g < 2; g++) begin
            if (c.type_mask[g] && hlen[g] != 0) begin
              if (!have || lighter(heap[g][0], heap[sel][0])) begin
                sel = g;
                have = 1;
              end
            end
          end
          if (!have) begin
            r.status = wlls_pkg::STAT_NONE;
          end else begin
            id = heap[sel][0];
            if (cnt[id] != wlls_pkg::COUNT_MAX) cnt[id] = cnt[id] + 1'b1;
            sift_down(sel, 0);
            r.chosen_id = wlls_pkg::ID_W'(id);
            r.chosen_count = cnt[id];
          end
        end
        default: begin
          id = c.target_id;
          r.chosen_id = wlls_pkg::ID_W'(id);
          if (!live[id]) begin
            r.status = wlls_pkg::STAT_BAD_ID;
          end else begin
            f = id / wlls_pkg::POOL_DEPTH;
            pos = slot_of[id];
            if (c.mode == wlls_pkg::MODE_CLOSE) begin
              if (cnt[id] != '0) cnt[id] = cnt[id] - 1'b1;
              sift_up(f, pos);
              r.chosen_count = cnt[id];
            end else begin
              r.chosen_count = cnt[id];
              live[id] = 0;
              hlen[f] = hlen[f] - 1;
              if (pos < hlen[f]) begin
                place(f, pos, heap[f][hlen[f]]);
                sift_up(f, pos);
                sift_down(f, pos);
              end
            end
          end
        end
      endcase
      r.families_seen = seen;
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_res(wlls_pkg::res_t got);
      wlls_pkg::res_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.chosen_id !== exp.chosen_id)
        report($sformatf("chosen_id %0d, expected %0d", got.chosen_id, exp.chosen_id));
      if (got.chosen_count !== exp.chosen_count)
        report($sformatf("chosen_count %0d, expected %0d", got.chosen_count,
                         exp.chosen_count));
      if (got.families_seen !== exp.families_seen)
        report($sformatf("families_seen %0d, expected %0d", got.families_seen,
                         exp.families_seen));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  wlls_pkg::cmd_t cmd_i;
  logic done_o;
  wlls_pkg::res_t res_o;
  load_scoreboard sb;
  int unsigned cycles;
  int idle_pct;

  weighted_least_loaded_selector i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_res(res_o);
  end

  task automatic send(wlls_pkg::cmd_t c);
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic wlls_pkg::cmd_t make(wlls_pkg::mode_e m, logic fam,
                                          logic [wlls_pkg::WEIGHT_W-1:0] w,
                                          logic [1:0] tm, logic [wlls_pkg::ID_W-1:0] t);
    wlls_pkg::cmd_t c;
    c.mode = m;
    c.family = fam;
    c.weight = w;
    c.type_mask = tm;
    c.target_id = t;
    return c;
  endfunction

  function automatic wlls_pkg::cmd_t rand_cmd(int add_pct);
    wlls_pkg::cmd_t c;
    int r;
    int tries;
    c = wlls_pkg::cmd_t'($urandom);
    r = $urandom_range(99);
    if (r < add_pct) begin
      c.mode = wlls_pkg::MODE_ADD;
      case ($urandom_range(3))
        0: c.weight = '0;
        1: c.weight = 16'hffff;
        2: c.weight = wlls_pkg::WEIGHT_W'($urandom_range(1, 8));
        default: c.weight = wlls_pkg::WEIGHT_W'($urandom);
      endcase
    end else if (r < add_pct + 35) begin
      c.mode = wlls_pkg::MODE_OPEN;
      if ($urandom_range(9) != 0) c.type_mask = 2'($urandom_range(1, 3));
    end else if (r < add_pct + 70) begin
      c.mode = wlls_pkg::MODE_CLOSE;
    end else begin
      c.mode = wlls_pkg::MODE_REMOVE;
    end
    if ($urandom_range(99) < 85) begin
      tries = 0;
      while (!sb.live[c.target_id] && tries < 64) begin
        c.target_id = wlls_pkg::ID_W'($urandom);
        tries++;
      end
    end
    return c;
  endfunction

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd3, '0));
    send(make(wlls_pkg::MODE_CLOSE, 1'b1, 16'hffff, 2'd0, 5'd31));
    send(make(wlls_pkg::MODE_ADD, 1'b0, 16'h0000, 2'd0, '0));
    send(make(wlls_pkg::MODE_ADD, 1'b0, 16'hffff, 2'd3, '0));
    send(make(wlls_pkg::MODE_ADD, 1'b1, 16'h0001, 2'd1, 5'd31));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd0, '0));
    send(make(wlls_pkg::MODE_OPEN, 1'b1, '0, 2'd3, '0));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd3, '0));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd3, '0));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd1, '0));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd2, '0));
    send(make(wlls_pkg::MODE_CLOSE, 1'b0, '0, 2'd0, 5'd16));
    send(make(wlls_pkg::MODE_CLOSE, 1'b0, '0, 2'd0, 5'd16));
    send(make(wlls_pkg::MODE_CLOSE, 1'b0, '0, 2'd0, 5'd16));
    send(make(wlls_pkg::MODE_CLOSE, 1'b0, '0, 2'd0, 5'd1));
    send(make(wlls_pkg::MODE_REMOVE, 1'b0, '0, 2'd0, 5'd0));
    send(make(wlls_pkg::MODE_REMOVE, 1'b0, '0, 2'd0, 5'd0));
    send(make(wlls_pkg::MODE_ADD, 1'b0, 16'd7, 2'd0, '0));
    send(make(wlls_pkg::MODE_ADD, 1'b0, 16'd3, 2'd0, '0));
    send(make(wlls_pkg::MODE_REMOVE, 1'b0, '0, 2'd0, 5'd1));
    send(make(wlls_pkg::MODE_REMOVE, 1'b1, '0, 2'd0, 5'd16));
    send(make(wlls_pkg::MODE_OPEN, 1'b0, '0, 2'd2, '0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 0;
        default: idle_pct = 8;
      endcase
      for (int n = 0; n < 240; n++) begin
        send(rand_cmd((ph == 0 || (n % 80) < 30) ? 55 : 15));
        if (n == 120) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
